// ===== sv/bvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared widths, constants and types of the battery voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

	localparam int SAMPLE_W    = 10;
	localparam int NUM_SAMPLES = 8;
	localparam int NUM_LANES   = NUM_SAMPLES / 2;
	localparam int PAIR_W      = SAMPLE_W + 1;
	localparam int SUM_W       = SAMPLE_W + 3;
	localparam int AVG_SHIFT   = 3;
	localparam int PERIOD_W    = 8;
	localparam int CFG_IDX_W   = 1;
	localparam int VOLT_W      = 7;

	localparam int SCALE_W     = 11;
	localparam int SCALE_SHIFT = 10;
	localparam int PROD_W      = SAMPLE_W + SCALE_W;
	localparam int CV_W        = PROD_W - SCALE_SHIFT;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int QP_W        = CV_W + RECIP_W;
	localparam int Q_W         = QP_W - RECIP_SHIFT;

	localparam logic [SCALE_W-1:0] SCALE          = SCALE_W'(1329);
	localparam logic [RECIP_W-1:0] RECIP_100      = RECIP_W'(5243);
	localparam logic [CV_W-1:0]    CENTS_PER_VOLT = CV_W'(100);

	localparam logic [PERIOD_W-1:0] REQUEST_PERIOD_RST = PERIOD_W'(6);
	localparam logic [PERIOD_W-1:0] IDLE_PERIOD_RST    = PERIOD_W'(50);

	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_PERIOD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD    = CFG_IDX_W'(1);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [PAIR_W-1:0]   pair_t;

	typedef struct packed {
		logic link_up;
		logic measured;
		logic invalid;
	} ctrl_t;

endpackage

// ===== sv/bvm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_if
// Valid/ready channels for tick input and voltage result.
// ----------------------------------------------------------------------------
interface bvm_in_if;
	logic                  valid;
	logic                  ready;
	logic                  link_down;
	logic                  volt_request;
	logic [bvm_pkg::SAMPLE_W-1:0] sample_0;
	logic [bvm_pkg::SAMPLE_W-1:0] sample_1;
	logic [bvm_pkg::SAMPLE_W-1:0] sample_2;
	logic [bvm_pkg::SAMPLE_W-1:0] sample_3;
	logic [bvm_pkg::SAMPLE_W-1:0] sample_4;
	logic [bvm_pkg::SAMPLE_W-1:0] sample_5;
	logic [bvm_pkg::SAMPLE_W-1:0] sample_6;
	logic [bvm_pkg::SAMPLE_W-1:0] sample_7;
	logic                  samples_invalid;

	modport source (output valid, link_down, volt_request, sample_0, sample_1,
		sample_2, sample_3, sample_4, sample_5, sample_6, sample_7, samples_invalid,
		input ready);
	modport sink (input valid, link_down, volt_request, sample_0, sample_1,
		sample_2, sample_3, sample_4, sample_5, sample_6, sample_7, samples_invalid,
		output ready);
endinterface

interface bvm_out_if;
	logic                        valid;
	logic                        ready;
	logic                        link_up;
	logic [bvm_pkg::VOLT_W-1:0]  volts_whole;
	logic [bvm_pkg::VOLT_W-1:0]  volts_hundredths;
	logic                        measured;

	modport source (output valid, link_up, volts_whole, volts_hundredths, measured,
		input ready);
	modport sink (input valid, link_up, volts_whole, volts_hundredths, measured,
		output ready);
endinterface

// ===== sv/bvm_tick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_tick
// Period registers and tick counter; flags the measuring ticks.
// ----------------------------------------------------------------------------
module bvm_tick (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bvm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bvm_pkg::PERIOD_W-1:0]      cfg_data,
	input  logic                              accept,
	input  logic                              volt_request,
	output logic                              measure
);

	logic [bvm_pkg::PERIOD_W-1:0] request_period_q;
	logic [bvm_pkg::PERIOD_W-1:0] idle_period_q;
	logic [bvm_pkg::PERIOD_W-1:0] tick_count_q;
	logic [bvm_pkg::PERIOD_W-1:0] count_next;
	logic [bvm_pkg::PERIOD_W-1:0] limit;

	assign count_next = tick_count_q + bvm_pkg::PERIOD_W'(1);
	assign limit      = volt_request ? request_period_q : idle_period_q;
	assign measure    = (count_next >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_period_q <= bvm_pkg::REQUEST_PERIOD_RST;
			idle_period_q    <= bvm_pkg::IDLE_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bvm_pkg::REG_REQUEST_PERIOD: request_period_q <= cfg_data;
				bvm_pkg::REG_IDLE_PERIOD:    idle_period_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
		end else if (accept) begin
			tick_count_q <= measure ? '0 : count_next;
		end
	end

endmodule

// ===== sv/bvm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_lane
// One adder lane: registered sum of a pair of ADC samples.
// ----------------------------------------------------------------------------
module bvm_lane (
	input  logic             clk,
	input  logic             en,
	input  bvm_pkg::sample_t sample_a,
	input  bvm_pkg::sample_t sample_b,
	output bvm_pkg::pair_t   pair_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= bvm_pkg::PAIR_W'(sample_a) + bvm_pkg::PAIR_W'(sample_b);
		end
	end

endmodule

// ===== sv/bvm_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvm_merge
// Combines lane sums, scales to centivolts, splits volts and hundredths
// and holds the last reading in the output register.
// ----------------------------------------------------------------------------
module bvm_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bvm_pkg::ctrl_t        ctrl_s0,
	input  bvm_pkg::pair_t        pair_s1 [bvm_pkg::NUM_LANES],
	bvm_out_if.source             result_out
);

	logic                            v_s1, v_s2, v_s3, v_s4, v_q;
	logic                            rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_q;
	bvm_pkg::ctrl_t                  ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic [bvm_pkg::SUM_W-1:0]       total;
	logic [bvm_pkg::SAMPLE_W-1:0]    avg_s2;
	logic [bvm_pkg::PROD_W-1:0]      prod_s3;
	logic [bvm_pkg::CV_W-1:0]        cv_next;
	logic [bvm_pkg::CV_W-1:0]        cv_s4;
	logic [bvm_pkg::QP_W-1:0]        qp_s4;
	logic [bvm_pkg::Q_W-1:0]         whole;
	logic [bvm_pkg::CV_W-1:0]        hundredths;
	logic                            link_q, measured_q;
	logic [bvm_pkg::VOLT_W-1:0]      whole_q, hund_q;

	assign rdy_q    = !v_q || result_out.ready;
	assign rdy_s4   = !v_s4 || rdy_q;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		total = '0;
		for (int i = 0; i < bvm_pkg::NUM_LANES; i++) begin
			total = total + bvm_pkg::SUM_W'(pair_s1[i]);
		end
	end

	assign cv_next    = ctrl_s3.invalid ? '0 : prod_s3[bvm_pkg::PROD_W-1:bvm_pkg::SCALE_SHIFT];
	assign whole      = qp_s4[bvm_pkg::QP_W-1:bvm_pkg::RECIP_SHIFT];
	assign hundredths = cv_s4 - bvm_pkg::CV_W'(whole) * bvm_pkg::CENTS_PER_VOLT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ctrl_s1 <= ctrl_s0;
		end
		if (rdy_s2 && v_s1) begin
			ctrl_s2 <= ctrl_s1;
			avg_s2  <= total[bvm_pkg::SUM_W-1:bvm_pkg::AVG_SHIFT];
		end
		if (rdy_s3 && v_s2) begin
			ctrl_s3 <= ctrl_s2;
			prod_s3 <= bvm_pkg::PROD_W'(avg_s2) * bvm_pkg::PROD_W'(bvm_pkg::SCALE);
		end
		if (rdy_s4 && v_s3) begin
			ctrl_s4 <= ctrl_s3;
			cv_s4   <= cv_next;
			qp_s4   <= bvm_pkg::QP_W'(cv_next) * bvm_pkg::QP_W'(bvm_pkg::RECIP_100);
		end
	end

	// output register doubles as the held reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q        <= 1'b0;
			link_q     <= 1'b0;
			measured_q <= 1'b0;
			whole_q    <= '0;
			hund_q     <= '0;
		end else if (rdy_q) begin
			v_q <= v_s4;
			if (v_s4) begin
				link_q     <= ctrl_s4.link_up;
				measured_q <= ctrl_s4.measured;
				if (ctrl_s4.measured) begin
					whole_q <= bvm_pkg::VOLT_W'(whole);
					hund_q  <= hundredths[bvm_pkg::VOLT_W-1:0];
				end
			end
		end
	end

	assign result_out.valid            = v_q;
	assign result_out.link_up          = link_q;
	assign result_out.measured         = measured_q;
	assign result_out.volts_whole      = whole_q;
	assign result_out.volts_hundredths = hund_q;

endmodule

// ===== sv/battery_voltage_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_monitor
// Periodic battery voltage measurement with link status.
// ----------------------------------------------------------------------------
// tick_in carries one update tick per transaction: link and request flags,
// eight ADC samples and a failed-conversion flag. result_out returns one
// transaction per tick: link state, held volts and hundredths, and whether
// that tick measured.
// the period registers are written through cfg_we / cfg_index / cfg_data,
// by the user only while no tick is in flight; the block does not check it.
// a new tick is taken every cycle unless the pipe stalls. four adder lanes
// sum sample pairs, then a merge pipe adds, scales and splits the value;
// the tick counter updates at acceptance. reset clears the counter and the
// held reading and loads the periods with 6 and 50. when the receiver
// stalls, results stay in the output register and the pipe keeps taking
// ticks until every stage is full.
// ----------------------------------------------------------------------------
module battery_voltage_monitor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bvm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bvm_pkg::PERIOD_W-1:0]    cfg_data,
	bvm_in_if.sink                          tick_in,
	bvm_out_if.source                       result_out
);

	logic             accept;
	logic             measure;
	logic             ready;
	bvm_pkg::ctrl_t   ctrl_s0;
	bvm_pkg::sample_t samples [bvm_pkg::NUM_SAMPLES];
	bvm_pkg::pair_t   pair_s1 [bvm_pkg::NUM_LANES];

	assign tick_in.ready = ready;
	assign accept        = tick_in.valid && ready;

	assign samples[0] = tick_in.sample_0;
	assign samples[1] = tick_in.sample_1;
	assign samples[2] = tick_in.sample_2;
	assign samples[3] = tick_in.sample_3;
	assign samples[4] = tick_in.sample_4;
	assign samples[5] = tick_in.sample_5;
	assign samples[6] = tick_in.sample_6;
	assign samples[7] = tick_in.sample_7;

	bvm_tick u_tick (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.volt_request (tick_in.volt_request),
		.measure      (measure)
	);

	for (genvar g = 0; g < bvm_pkg::NUM_LANES; g++) begin : g_lane
		bvm_lane u_lane (
			.clk      (clk),
			.en       (accept),
			.sample_a (samples[2*g]),
			.sample_b (samples[2*g+1]),
			.pair_s1  (pair_s1[g])
		);
	end

	assign ctrl_s0.link_up  = !tick_in.link_down;
	assign ctrl_s0.measured = measure;
	assign ctrl_s0.invalid  = tick_in.samples_invalid;

	bvm_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (tick_in.valid),
		.in_ready   (ready),
		.ctrl_s0    (ctrl_s0),
		.pair_s1    (pair_s1),
		.result_out (result_out)
	);

endmodule
